/* src/signal_peak_seek_unit_macros.svh */
// Assertion macros for the signal peak seek RTL.
`ifndef SIGNAL_PEAK_SEEK_UNIT_MACROS_SVH
`define SIGNAL_PEAK_SEEK_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SPSK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SPSK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/spsk_pkg.sv */
// Package: shared types, codes and constants of the signal peak seek unit.
`default_nettype none
package spsk_pkg;

  localparam int unsigned SPSK_READS_PER_STEP = 128;

  localparam int unsigned FREQ_W  = 11;
  localparam int unsigned LEVEL_W = 10;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CFG_AW  = 2;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_NOISE_THR = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_PEAK_THR  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_FREQ_LOW  = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_FREQ_HIGH = 2'd3;

  localparam logic [LEVEL_W-1:0] NOISE_THR_RST = 10'd20;
  localparam logic [LEVEL_W-1:0] PEAK_THR_RST  = 10'd200;
  localparam logic [FREQ_W-1:0]  FREQ_LOW_RST  = 11'd530;
  localparam logic [FREQ_W-1:0]  FREQ_HIGH_RST = 11'd1700;

  // item mode codes
  localparam logic MODE_START  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [FREQ_W-1:0]  start_freq;
    logic               seek_up;
    logic [LEVEL_W-1:0] level;
  } in_item_t;

  typedef struct packed {
    logic [FREQ_W-1:0] tune_freq;
    logic              done_res;
    logic              found;
  } out_item_t;

  // classified command held in the queue between front and back
  typedef struct packed {
    logic               is_start;
    logic [FREQ_W-1:0]  start_freq;
    logic               seek_up;
    logic [LEVEL_W-1:0] level;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_FIRST  = 3'b010,
    PH_GATHER = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    SS_BEGINNING = 3'b001,
    SS_RISING    = 3'b010,
    SS_FALLING   = 3'b100
  } seek_state_t;

  // True while the next step still lies strictly inside the bounds.
  function automatic logic freq_in_range(input logic [FREQ_W-1:0] f,
                                         input logic up,
                                         input logic [FREQ_W-1:0] low,
                                         input logic [FREQ_W-1:0] high);
    logic [FREQ_W:0] f_ext;
    f_ext = {1'b0, f};
    if (up) begin
      freq_in_range = (f_ext + (FREQ_W+1)'(1)) < {1'b0, high};
    end else begin
      freq_in_range = f_ext > ({1'b0, low} + (FREQ_W+1)'(1));
    end
  endfunction

endpackage
`default_nettype wire

/* src/spsk_stream_if.sv */
// Interface: valid/ready stream channel carrying one payload per transaction.
`default_nettype none
interface spsk_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/spsk_front.sv */
// Front end: accepts input transactions, classifies them and queues them.
`default_nettype none
module spsk_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  spsk_stream_if.sink               in_if,
  output spsk_pkg::queue_head_t     head,
  input  wire logic                 head_pop
);
  import spsk_pkg::*;

  localparam int unsigned DEPTH = 2;

  cmd_t       mem_r [DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  cmd_t       cmd_in;

  assign in_if.ready = (count_r != 2'(DEPTH));
  assign push        = in_if.valid && in_if.ready;

  always_comb begin
    cmd_in.is_start   = (in_if.data.mode == MODE_START);
    cmd_in.start_freq = in_if.data.start_freq;
    cmd_in.seek_up    = in_if.data.seek_up;
    cmd_in.level      = in_if.data.level;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = head_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(head_pop);
  end

  assign head.valid = (count_r != 2'd0);
  assign head.cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

/* src/spsk_back.sv */
// Back end: seek engine with group max, rise/fall tracking and result register.
`default_nettype none
`include "signal_peak_seek_unit_macros.svh"
module spsk_back #(
  parameter int unsigned READS_PER_STEP = spsk_pkg::SPSK_READS_PER_STEP
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [spsk_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [spsk_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire spsk_pkg::queue_head_t        head,
  output logic                              head_pop,
  spsk_stream_if.source                     out_if
);
  import spsk_pkg::*;

  localparam int unsigned CW = $clog2(READS_PER_STEP + 1);
  localparam logic [CW-1:0] LAST_READ = CW'(READS_PER_STEP);

  // configuration
  logic [LEVEL_W-1:0] noise_thr_r, peak_thr_r;
  logic [FREQ_W-1:0]  freq_low_r, freq_high_r;

  // seek state
  phase_t             phase_r, phase_nxt;
  seek_state_t        seek_r, seek_nxt;
  logic               dir_up_r, dir_up_nxt;
  logic [FREQ_W-1:0]  cur_freq_r, cur_freq_nxt;
  logic [FREQ_W-1:0]  peak_freq_r, peak_freq_nxt;
  logic [LEVEL_W-1:0] prev_lvl_r, prev_lvl_nxt;
  logic [LEVEL_W-1:0] knee_lvl_r, knee_lvl_nxt;
  logic [LEVEL_W-1:0] peak_lvl_r, peak_lvl_nxt;
  logic [LEVEL_W-1:0] run_max_r, run_max_nxt;
  logic [CW-1:0]      read_cnt_r, read_cnt_nxt;

  // result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic               emit;
  logic               accepted;
  logic [LEVEL_W-1:0] grp_max;
  logic [LEVEL_W:0]   prev_plus_noise, grp_plus_noise;
  logic [LEVEL_W:0]   grp_plus_peak, knee_plus_peak;
  logic [FREQ_W-1:0]  stepped_freq;

  assign head_pop = head.valid && (!out_valid_r || out_if.ready);

  assign grp_max = ((read_cnt_r == '0) || (head.cmd.level > run_max_r)) ?
                   head.cmd.level : run_max_r;
  assign prev_plus_noise = {1'b0, prev_lvl_r} + {1'b0, noise_thr_r};
  assign grp_plus_noise  = {1'b0, grp_max} + {1'b0, noise_thr_r};
  assign grp_plus_peak   = {1'b0, grp_max} + {1'b0, peak_thr_r};
  assign knee_plus_peak  = {1'b0, knee_lvl_r} + {1'b0, peak_thr_r};
  assign stepped_freq    = dir_up_r ? (cur_freq_r + FREQ_W'(1)) :
                                      (cur_freq_r - FREQ_W'(1));

  always_comb begin
    phase_nxt     = phase_r;
    seek_nxt      = seek_r;
    dir_up_nxt    = dir_up_r;
    cur_freq_nxt  = cur_freq_r;
    peak_freq_nxt = peak_freq_r;
    prev_lvl_nxt  = prev_lvl_r;
    knee_lvl_nxt  = knee_lvl_r;
    peak_lvl_nxt  = peak_lvl_r;
    run_max_nxt   = run_max_r;
    read_cnt_nxt  = read_cnt_r;
    emit          = 1'b0;
    accepted      = 1'b0;
    out_data_nxt  = out_data_r;

    if (head_pop) begin
      if (head.cmd.is_start) begin
        cur_freq_nxt  = head.cmd.start_freq;
        dir_up_nxt    = head.cmd.seek_up;
        seek_nxt      = SS_BEGINNING;
        peak_freq_nxt = '0;
        prev_lvl_nxt  = '0;
        knee_lvl_nxt  = '0;
        peak_lvl_nxt  = '0;
        run_max_nxt   = '0;
        read_cnt_nxt  = '0;
        if (freq_in_range(head.cmd.start_freq, head.cmd.seek_up,
                          freq_low_r, freq_high_r)) begin
          phase_nxt = PH_FIRST;
        end else begin
          phase_nxt              = PH_IDLE;
          emit                   = 1'b1;
          out_data_nxt.tune_freq = head.cmd.start_freq;
          out_data_nxt.done_res  = 1'b1;
          out_data_nxt.found     = 1'b0;
        end
      end else begin
        case (phase_r)
          PH_IDLE: begin
            // drop samples while no seek runs
          end
          PH_FIRST: begin
            prev_lvl_nxt = head.cmd.level;
            read_cnt_nxt = '0;
            phase_nxt    = PH_GATHER;
          end
          PH_GATHER: begin
            run_max_nxt = grp_max;
            if (read_cnt_r != LAST_READ) begin
              read_cnt_nxt = read_cnt_r + CW'(1);
            end else begin
              read_cnt_nxt = '0;
              prev_lvl_nxt = grp_max;
              case (seek_r)
                SS_BEGINNING: begin
                  if ({1'b0, grp_max} > prev_plus_noise) begin
                    seek_nxt     = SS_RISING;
                    knee_lvl_nxt = grp_max;
                  end
                end
                SS_RISING: begin
                  if ({1'b0, prev_lvl_r} > grp_plus_noise) begin
                    seek_nxt      = SS_FALLING;
                    peak_lvl_nxt  = grp_max;
                    peak_freq_nxt = cur_freq_r;
                  end
                end
                SS_FALLING: begin
                  if ({1'b0, grp_max} > prev_plus_noise) begin
                    seek_nxt      = SS_RISING;
                    peak_lvl_nxt  = grp_max;
                    peak_freq_nxt = cur_freq_r;
                  end else if (({1'b0, peak_lvl_r} > grp_plus_peak) &&
                               ({1'b0, peak_lvl_r} > knee_plus_peak)) begin
                    accepted = 1'b1;
                  end
                end
                default: begin
                  seek_nxt = SS_BEGINNING;
                end
              endcase

              emit = 1'b1;
              if (accepted) begin
                phase_nxt              = PH_IDLE;
                out_data_nxt.tune_freq = peak_freq_r;
                out_data_nxt.done_res  = 1'b1;
                out_data_nxt.found     = 1'b1;
              end else begin
                cur_freq_nxt           = stepped_freq;
                out_data_nxt.tune_freq = stepped_freq;
                out_data_nxt.found     = 1'b0;
                if (freq_in_range(stepped_freq, dir_up_r, freq_low_r, freq_high_r)) begin
                  out_data_nxt.done_res = 1'b0;
                end else begin
                  phase_nxt             = PH_IDLE;
                  out_data_nxt.done_res = 1'b1;
                end
              end
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_thr_r <= NOISE_THR_RST;
      peak_thr_r  <= PEAK_THR_RST;
      freq_low_r  <= FREQ_LOW_RST;
      freq_high_r <= FREQ_HIGH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_NOISE_THR: noise_thr_r <= cfg_wdata[LEVEL_W-1:0];
        CFG_PEAK_THR:  peak_thr_r  <= cfg_wdata[LEVEL_W-1:0];
        CFG_FREQ_LOW:  freq_low_r  <= cfg_wdata[FREQ_W-1:0];
        CFG_FREQ_HIGH: freq_high_r <= cfg_wdata[FREQ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      seek_r      <= SS_BEGINNING;
      dir_up_r    <= 1'b0;
      cur_freq_r  <= '0;
      peak_freq_r <= '0;
      prev_lvl_r  <= '0;
      knee_lvl_r  <= '0;
      peak_lvl_r  <= '0;
      run_max_r   <= '0;
      read_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      seek_r      <= seek_nxt;
      dir_up_r    <= dir_up_nxt;
      cur_freq_r  <= cur_freq_nxt;
      peak_freq_r <= peak_freq_nxt;
      prev_lvl_r  <= prev_lvl_nxt;
      knee_lvl_r  <= knee_lvl_nxt;
      peak_lvl_r  <= peak_lvl_nxt;
      run_max_r   <= run_max_nxt;
      read_cnt_r  <= read_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  `SPSK_ASSERT_NOW(a_found_ends_seek, out_valid_r && out_data_r.found, out_data_r.done_res, "found result without done")
  `SPSK_ASSERT_NEXT(a_done_goes_idle, emit && out_data_nxt.done_res, phase_r == PH_IDLE, "seek ended but phase not idle")
  `SPSK_ASSERT_NOW(a_count_bound, phase_r == PH_GATHER, read_cnt_r <= LAST_READ, "read count past group end")
  `SPSK_ASSERT_NOW(a_emit_slot_free, emit, head_pop && (!out_valid_r || out_if.ready), "result overwrites a pending one")

endmodule
`default_nettype wire

/* src/signal_peak_seek_unit.sv */
// Path: an input transaction passes the queue and then the result register on its way to a result transaction.
// Throughput: one item per cycle; the seek engine retires one queued item each cycle
// that the result register is free or being drained.
// A sample that closes a group of READS_PER_STEP+1, or a start outside the bounds,
// gives one result; other items give none.
// Reset: synchronous active-low rst_n clears queue, seek state and result valid, loads defaults.
`default_nettype none
module signal_peak_seek_unit #(
  parameter int unsigned READS_PER_STEP = spsk_pkg::SPSK_READS_PER_STEP
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [spsk_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [spsk_pkg::CFG_W-1:0]  cfg_wdata,
  spsk_stream_if.sink                      in_if,
  spsk_stream_if.source                    out_if
);
  import spsk_pkg::*;

  queue_head_t head;
  logic        head_pop;

  spsk_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .head     (head),
    .head_pop (head_pop)
  );

  spsk_back #(
    .READS_PER_STEP (READS_PER_STEP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .head_pop  (head_pop),
    .out_if    (out_if)
  );

endmodule
`default_nettype wire
